[sv/clcd_pkg.sv]
// Shared types, constants and the microcode table of the character LCD sequencer.
`timescale 1ns / 1ps

package clcd_pkg;

    localparam int WAIT_W   = 16;
    localparam int STROBE_W = 8;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 2;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STROBE_WAIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_SETTLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SETTLE   = 2'd2;

    localparam logic [STROBE_W-1:0] STROBE_WAIT_RST = 8'd2;
    localparam logic [WAIT_W-1:0]   CTRL_SETTLE_RST = 16'd30;
    localparam logic [WAIT_W-1:0]   DATA_SETTLE_RST = 16'd20;

    // Power-up waits
    localparam logic [WAIT_W-1:0] PRE_WAIT_30K = 16'd30000;
    localparam logic [WAIT_W-1:0] PRE_WAIT_10K = 16'd10000;
    localparam logic [WAIT_W-1:0] PRE_WAIT_1K  = 16'd1000;
    localparam logic [WAIT_W-1:0] CLEAR_EXTRA_WAIT = 16'd1000;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CURSOR_ROW0_BASE = 8'h80;
    localparam logic [BYTE_W-1:0] CURSOR_ROW1_BASE = 8'hC0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 2'd0,
        CMD_CTRL   = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_CURSOR = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HIGH  = 2'd1,
        NIB_LOW   = 2'd2
    } nib_src_t;

    typedef enum logic [1:0] {
        PRE_NONE = 2'd0,
        PRE_30K  = 2'd1,
        PRE_10K  = 2'd2,
        PRE_1K   = 2'd3
    } pre_sel_t;

    typedef enum logic [2:0] {
        AFT_NONE        = 3'd0,
        AFT_STROBE      = 3'd1,
        AFT_SETTLE      = 3'd2,
        AFT_SETTLE_LONG = 3'd3,
        AFT_DATA        = 3'd4
    } after_sel_t;

    // One microcode word: one enable strobe
    typedef struct packed {
        logic             rs;
        nib_src_t         nib_src;
        logic [NIB_W-1:0] nib_const;
        pre_sel_t         pre_sel;
        after_sel_t       after_sel;
        logic             last;
    } uword_t;

    typedef struct packed {
        logic [STROBE_W-1:0] strobe_wait;
        logic [WAIT_W-1:0]   ctrl_settle;
        logic [WAIT_W-1:0]   data_settle;
    } cfg_t;

    typedef struct packed {
        logic [WAIT_W-1:0]   pre_wait;
        logic                reg_select;
        logic [NIB_W-1:0]    nibble;
        logic [STROBE_W-1:0] lead_wait;
        logic [STROBE_W-1:0] pulse_wait;
        logic [WAIT_W-1:0]   after_wait;
        logic                last;
    } strobe_t;

    localparam int UCODE_DEPTH = 18;
    localparam int PC_W = $clog2(UCODE_DEPTH);

    localparam logic [PC_W-1:0] ENTRY_INIT = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_CTRL = 5'd14;
    localparam logic [PC_W-1:0] ENTRY_DATA = 5'd16;

    function automatic uword_t uw(input logic rs, input nib_src_t src,
                                  input logic [NIB_W-1:0] k, input pre_sel_t pre,
                                  input after_sel_t aft, input logic last);
        uword_t w;
        w.rs        = rs;
        w.nib_src   = src;
        w.nib_const = k;
        w.pre_sel   = pre;
        w.after_sel = aft;
        w.last      = last;
        return w;
    endfunction

    // Control store
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            // init: power-up nibbles
            5'd0:  w = uw(1'b0, NIB_CONST, 4'h3, PRE_30K,  AFT_STROBE, 1'b0);
            5'd1:  w = uw(1'b0, NIB_CONST, 4'h3, PRE_10K,  AFT_STROBE, 1'b0);
            5'd2:  w = uw(1'b0, NIB_CONST, 4'h3, PRE_1K,   AFT_STROBE, 1'b0);
            5'd3:  w = uw(1'b0, NIB_CONST, 4'h2, PRE_NONE, AFT_STROBE, 1'b0);
            // function set 0x2c
            5'd4:  w = uw(1'b0, NIB_CONST, 4'h2, PRE_NONE, AFT_STROBE, 1'b0);
            5'd5:  w = uw(1'b0, NIB_CONST, 4'hC, PRE_NONE, AFT_SETTLE, 1'b0);
            // display on 0x0f
            5'd6:  w = uw(1'b0, NIB_CONST, 4'h0, PRE_NONE, AFT_STROBE, 1'b0);
            5'd7:  w = uw(1'b0, NIB_CONST, 4'hF, PRE_NONE, AFT_SETTLE, 1'b0);
            // entry mode 0x06
            5'd8:  w = uw(1'b0, NIB_CONST, 4'h0, PRE_NONE, AFT_STROBE, 1'b0);
            5'd9:  w = uw(1'b0, NIB_CONST, 4'h6, PRE_NONE, AFT_SETTLE, 1'b0);
            // shift 0x1c
            5'd10: w = uw(1'b0, NIB_CONST, 4'h1, PRE_NONE, AFT_STROBE, 1'b0);
            5'd11: w = uw(1'b0, NIB_CONST, 4'hC, PRE_NONE, AFT_SETTLE, 1'b0);
            // clear 0x01, long settle
            5'd12: w = uw(1'b0, NIB_CONST, 4'h0, PRE_NONE, AFT_STROBE, 1'b0);
            5'd13: w = uw(1'b0, NIB_CONST, 4'h1, PRE_NONE, AFT_SETTLE_LONG, 1'b1);
            // control byte / cursor
            5'd14: w = uw(1'b0, NIB_HIGH,  4'h0, PRE_NONE, AFT_STROBE, 1'b0);
            5'd15: w = uw(1'b0, NIB_LOW,   4'h0, PRE_NONE, AFT_SETTLE, 1'b1);
            // data byte
            5'd16: w = uw(1'b1, NIB_HIGH,  4'h0, PRE_NONE, AFT_NONE,   1'b0);
            5'd17: w = uw(1'b1, NIB_LOW,   4'h0, PRE_NONE, AFT_DATA,   1'b1);
            default: w = uw(1'b0, NIB_CONST, 4'h0, PRE_NONE, AFT_NONE, 1'b1);
        endcase
        return w;
    endfunction

endpackage

[sv/clcd_if.sv]
// Command and strobe channel interfaces.
`timescale 1ns / 1ps

interface clcd_cmd_if
    import clcd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] value;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;

    modport source (output valid, output command, output value, output column,
                    output row, input ready);
    modport sink   (input valid, input command, input value, input column,
                    input row, output ready);
endinterface

interface clcd_strobe_if
    import clcd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WAIT_W-1:0]   pre_wait;
    logic                reg_select;
    logic [NIB_W-1:0]    nibble;
    logic [STROBE_W-1:0] lead_wait;
    logic [STROBE_W-1:0] pulse_wait;
    logic [WAIT_W-1:0]   after_wait;
    logic                last;

    modport source (output valid, output pre_wait, output reg_select, output nibble,
                    output lead_wait, output pulse_wait, output after_wait,
                    output last, input ready);
    modport sink   (input valid, input pre_wait, input reg_select, input nibble,
                    input lead_wait, input pulse_wait, input after_wait,
                    input last, output ready);
endinterface

[sv/clcd_strobe_gen.sv]
// Datapath: turns one microcode word and the operand byte into strobe fields.
`timescale 1ns / 1ps

module clcd_strobe_gen
    import clcd_pkg::*;
(
    input  uword_t            word,
    input  logic [BYTE_W-1:0] operand,
    input  cfg_t              cfg,
    output strobe_t           strobe
);

    localparam int SUM_W = WAIT_W + 2;

    logic [SUM_W-1:0] after_sum;
    logic [SUM_W-1:0] settle_term;
    logic [SUM_W-1:0] extra_term;

    always_comb
    begin
        settle_term = '0;
        extra_term  = '0;
        if (word.after_sel == AFT_SETTLE || word.after_sel == AFT_SETTLE_LONG)
        begin
            settle_term = {2'b00, cfg.ctrl_settle};
        end
        if (word.after_sel == AFT_SETTLE_LONG)
        begin
            extra_term = {2'b00, CLEAR_EXTRA_WAIT};
        end
        after_sum = {{(SUM_W-STROBE_W){1'b0}}, cfg.strobe_wait} + settle_term + extra_term;
    end

    always_comb
    begin
        strobe.reg_select = word.rs;
        strobe.last       = word.last;

        unique case (word.nib_src)
            NIB_HIGH: strobe.nibble = operand[BYTE_W-1:NIB_W];
            NIB_LOW:  strobe.nibble = operand[NIB_W-1:0];
            default:  strobe.nibble = word.nib_const;
        endcase

        unique case (word.pre_sel)
            PRE_30K: strobe.pre_wait = PRE_WAIT_30K;
            PRE_10K: strobe.pre_wait = PRE_WAIT_10K;
            PRE_1K:  strobe.pre_wait = PRE_WAIT_1K;
            default: strobe.pre_wait = '0;
        endcase

        // data strobes carry no waits inside the strobe
        strobe.lead_wait  = word.rs ? '0 : cfg.strobe_wait;
        strobe.pulse_wait = word.rs ? '0 : cfg.strobe_wait;

        unique case (word.after_sel)
            AFT_NONE:   strobe.after_wait = '0;
            AFT_DATA:   strobe.after_wait = cfg.data_settle;
            AFT_STROBE: strobe.after_wait = {{(WAIT_W-STROBE_W){1'b0}}, cfg.strobe_wait};
            default:    strobe.after_wait = (after_sum > {2'b00, WAIT_MAX}) ?
                                            WAIT_MAX : after_sum[WAIT_W-1:0];
        endcase
    end

endmodule

[sv/char_lcd_4bit_write_sequencer.sv]
// Top level: character LCD 4-bit write sequencer, microcoded.
`timescale 1ns / 1ps

// Expands each command into a run of enable strobes for an HD44780-style
// display on a 4-bit bus, one strobe per nibble transferred. A step counter walks
// a small control store; each word yields one strobe. When the strobe sink is
// always ready a strobe leaves every cycle while a run is in progress. Init
// yields 14 strobes, a control, data or cursor byte 2, and a cursor on rows 2
// or 3 none.
// The next command is taken once the last strobe of the current run is in the
// output register, even while that strobe still waits to be transferred.
// Configuration writes are taken at any time but should be made while idle.

module char_lcd_4bit_write_sequencer
    import clcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    clcd_cmd_if.sink              cmd,
    clcd_strobe_if.source         strobe
);

    logic                busy_reg, busy_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   operand_reg;
    strobe_t             out_reg;
    cfg_t                cfg_reg;

    logic    cmd_xfer;
    logic    advance;
    logic    drop_cmd;
    uword_t  word;
    strobe_t gen;
    logic [BYTE_W-1:0] cursor_byte;

    assign cmd.ready = !busy_reg;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign advance   = busy_reg && (!out_valid_reg || strobe.ready);
    assign word      = ucode_rom(pc_reg);

    // rows 2 and 3 produce nothing
    assign drop_cmd = (cmd.command == CMD_CURSOR) && cmd.row[1];

    assign cursor_byte = (cmd.row[0] ? CURSOR_ROW1_BASE : CURSOR_ROW0_BASE)
                         + {{(BYTE_W-COL_W){1'b0}}, cmd.column};

    clcd_strobe_gen u_gen (
        .word    (word),
        .operand (operand_reg),
        .cfg     (cfg_reg),
        .strobe  (gen)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (word.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
        else if (strobe.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd_xfer && !drop_cmd)
        begin
            busy_next = 1'b1;
            unique case (cmd.command)
                CMD_INIT: pc_next = ENTRY_INIT;
                CMD_DATA: pc_next = ENTRY_DATA;
                default:  pc_next = ENTRY_CTRL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg.strobe_wait <= STROBE_WAIT_RST;
            cfg_reg.ctrl_settle <= CTRL_SETTLE_RST;
            cfg_reg.data_settle <= DATA_SETTLE_RST;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STROBE_WAIT: cfg_reg.strobe_wait <= cfg_data[STROBE_W-1:0];
                    REG_CTRL_SETTLE: cfg_reg.ctrl_settle <= cfg_data[WAIT_W-1:0];
                    REG_DATA_SETTLE: cfg_reg.data_settle <= cfg_data[WAIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            operand_reg <= (cmd.command == CMD_CURSOR) ? cursor_byte : cmd.value;
        end
        if (advance)
        begin
            out_reg <= gen;
        end
    end

    assign strobe.valid      = out_valid_reg;
    assign strobe.pre_wait   = out_reg.pre_wait;
    assign strobe.reg_select = out_reg.reg_select;
    assign strobe.nibble     = out_reg.nibble;
    assign strobe.lead_wait  = out_reg.lead_wait;
    assign strobe.pulse_wait = out_reg.pulse_wait;
    assign strobe.after_wait = out_reg.after_wait;
    assign strobe.last       = out_reg.last;

endmodule

[sv/clcd_checker.sv]
// Port-level checker for the LCD sequencer, bound to the top level.
`timescale 1ns / 1ps

module clcd_checker
    import clcd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic [CMD_W-1:0]    cmd_command,
    input logic                out_valid,
    input logic                out_ready,
    input logic                out_reg_select,
    input logic [NIB_W-1:0]    out_nibble,
    input logic [WAIT_W-1:0]   out_pre_wait,
    input logic [STROBE_W-1:0] out_lead_wait,
    input logic [STROBE_W-1:0] out_pulse_wait
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("strobe valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_nibble))
        else $error("strobe nibble changed while stalled");

    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_command == CMD_INIT |=> !cmd_ready)
        else $error("command taken right after init");

    a_data_nowait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_reg_select |->
            out_lead_wait == '0 && out_pulse_wait == '0 && out_pre_wait == '0)
        else $error("data strobe carries waits");

    a_ctrl_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_reg_select |-> out_lead_wait == out_pulse_wait)
        else $error("control strobe lead and pulse differ");

endmodule

bind char_lcd_4bit_write_sequencer clcd_checker u_clcd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_command    (cmd.command),
    .out_valid      (strobe.valid),
    .out_ready      (strobe.ready),
    .out_reg_select (strobe.reg_select),
    .out_nibble     (strobe.nibble),
    .out_pre_wait   (strobe.pre_wait),
    .out_lead_wait  (strobe.lead_wait),
    .out_pulse_wait (strobe.pulse_wait)
);

[test/tb_top.sv]
// Self-checking testbench for the character LCD 4-bit write sequencer.
`timescale 1ns / 1ps

module tb_top;
    import clcd_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int DRAIN_LIMIT = 200000;
    localparam int unsigned WAIT_CAP = 65535;
    localparam int unsigned POWERUP_WAIT_A = 30000;
    localparam int unsigned POWERUP_WAIT_B = 10000;
    localparam int unsigned POWERUP_WAIT_C = 1000;
    localparam int unsigned CLEAR_SETTLE = 1000;
    localparam logic [NIB_W-1:0] SYNC_NIBBLE = 4'h3;
    localparam logic [NIB_W-1:0] BUS4_NIBBLE = 4'h2;
    // function set, display on, entry mode, shift, clear
    localparam logic [39:0] INIT_SEQ = 40'h2c_0f_06_1c_01;
    localparam logic [BYTE_W-1:0] ROW0_BASE = 8'h80;
    localparam logic [BYTE_W-1:0] ROW1_BASE = 8'hC0;
    localparam logic [ROW_W-1:0] TOP_ROW = 2'd0;
    localparam logic [ROW_W-1:0] BOTTOM_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [STROBE_W-1:0] DEFAULT_STROBE = 8'd2;
    localparam logic [WAIT_W-1:0] DEFAULT_CTRL_SETTLE = 16'd30;
    localparam logic [WAIT_W-1:0] DEFAULT_DATA_SETTLE = 16'd20;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    clcd_cmd_if    cmd_bus ();
    clcd_strobe_if strobe_bus ();

    cfg_t    shadow_cfg;
    strobe_t pending_strobes[$];
    int      fault_count;
    bit      no_idle;
    int      sink_hold_len;

    char_lcd_4bit_write_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .strobe    (strobe_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------- expected strobe runs ----------------

    function automatic int unsigned clip_wait(input int unsigned w);
        return (w > WAIT_CAP) ? WAIT_CAP : w;
    endfunction

    function automatic void queue_strobe(input int unsigned pre, input logic rs,
                                         input logic [NIB_W-1:0] nib,
                                         input logic [STROBE_W-1:0] lead,
                                         input logic [STROBE_W-1:0] pulse,
                                         input int unsigned after);
        strobe_t s;
        s.pre_wait   = WAIT_W'(clip_wait(pre));
        s.reg_select = rs;
        s.nibble     = nib;
        s.lead_wait  = lead;
        s.pulse_wait = pulse;
        s.after_wait = WAIT_W'(clip_wait(after));
        s.last       = 1'b0;
        pending_strobes.push_back(s);
    endfunction

    function automatic void queue_ctrl_nibble(input int unsigned pre,
                                              input logic [NIB_W-1:0] nib,
                                              input int unsigned extra);
        int unsigned sw;
        sw = 32'(shadow_cfg.strobe_wait);
        queue_strobe(pre, 1'b0, nib, shadow_cfg.strobe_wait, shadow_cfg.strobe_wait,
                     sw + extra);
    endfunction

    function automatic void queue_ctrl_byte(input logic [BYTE_W-1:0] b,
                                            input int unsigned extra);
        int unsigned settle;
        settle = 32'(shadow_cfg.ctrl_settle);
        queue_ctrl_nibble(0, b[7:4], 0);
        queue_ctrl_nibble(0, b[3:0], settle + extra);
    endfunction

    function automatic void expand_command(input cmd_e_t c, input logic [BYTE_W-1:0] v,
                                           input logic [COL_W-1:0] col,
                                           input logic [ROW_W-1:0] row);
        int start_len;
        int unsigned data_settle;
        logic [BYTE_W-1:0] cursor_byte;
        strobe_t tail;
        start_len = pending_strobes.size();
        data_settle = 32'(shadow_cfg.data_settle);
        case (c)
            CMD_INIT:
            begin
                queue_ctrl_nibble(POWERUP_WAIT_A, SYNC_NIBBLE, 0);
                queue_ctrl_nibble(POWERUP_WAIT_B, SYNC_NIBBLE, 0);
                queue_ctrl_nibble(POWERUP_WAIT_C, SYNC_NIBBLE, 0);
                queue_ctrl_nibble(0, BUS4_NIBBLE, 0);
                for (int i = 0; i < 5; i++)
                    queue_ctrl_byte(INIT_SEQ[39 - 8 * i -: 8], (i == 4) ? CLEAR_SETTLE : 0);
            end
            CMD_CTRL:
                queue_ctrl_byte(v, 0);
            CMD_DATA:
            begin
                queue_strobe(0, 1'b1, v[7:4], '0, '0, 0);
                queue_strobe(0, 1'b1, v[3:0], '0, '0, data_settle);
            end
            default:
            begin
                // rows two and three give no strobe at all
                if (row == TOP_ROW)
                begin
                    cursor_byte = ROW0_BASE + {2'b00, col};
                    queue_ctrl_byte(cursor_byte, 0);
                end
                else if (row == BOTTOM_ROW)
                begin
                    cursor_byte = ROW1_BASE + {2'b00, col};
                    queue_ctrl_byte(cursor_byte, 0);
                end
            end
        endcase
        if (pending_strobes.size() > start_len)
        begin
            tail = pending_strobes.pop_back();
            tail.last = 1'b1;
            pending_strobes.push_back(tail);
        end
    endfunction

    // ---------------- strobe sink and checker ----------------

    initial
    begin : sink_side
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        strobe_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_len > 0)
            begin
                strobe_bus.ready <= 1'b0;
                sink_hold_len--;
            end
            else if (no_idle)
                strobe_bus.ready <= 1'b1;
            else
            begin
                if (stall_left == 0 && run_left == 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                        stall_left = $urandom_range(1, 18);
                    else
                        run_left = $urandom_range(1, 40);
                end
                if (stall_left > 0)
                begin
                    strobe_bus.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    strobe_bus.ready <= 1'b1;
                    run_left--;
                end
            end
        end
    end

    function automatic string strobe_text(input strobe_t s);
        return $sformatf("pre=%0d rs=%0d nib=%h lead=%0d pulse=%0d after=%0d last=%0d",
                         s.pre_wait, s.reg_select, s.nibble, s.lead_wait, s.pulse_wait,
                         s.after_wait, s.last);
    endfunction

    always @(posedge clk)
    begin : strobe_check
        strobe_t got;
        strobe_t want;
        if (rst_n && strobe_bus.valid && strobe_bus.ready)
        begin
            got.pre_wait   = strobe_bus.pre_wait;
            got.reg_select = strobe_bus.reg_select;
            got.nibble     = strobe_bus.nibble;
            got.lead_wait  = strobe_bus.lead_wait;
            got.pulse_wait = strobe_bus.pulse_wait;
            got.after_wait = strobe_bus.after_wait;
            got.last       = strobe_bus.last;
            if (pending_strobes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: strobe with none expected: %s", $realtime, strobe_text(got));
            end
            else
            begin
                want = pending_strobes.pop_front();
                if (got !== want)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: strobe mismatch\n  exp %s\n  got %s", $realtime,
                                 strobe_text(want), strobe_text(got));
                end
            end
        end
    end

    // ---------------- command source and register writes ----------------

    task automatic send_command(input cmd_e_t c, input logic [BYTE_W-1:0] v,
                                input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= c;
        cmd_bus.value   <= v;
        cmd_bus.column  <= col;
        cmd_bus.row     <= row;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        expand_command(c, v, col, row);
    endtask

    task automatic send_random_command();
        cmd_e_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            c = CMD_INIT;
        else if (pick < 35)
            c = CMD_CTRL;
        else if (pick < 70)
            c = CMD_DATA;
        else
            c = CMD_CURSOR;
        send_command(c, BYTE_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                     ROW_W'($urandom_range(0, 3)));
    endtask

    // wait until every expected strobe has arrived; a cursor on rows 2/3 expects none
    task automatic settle_all();
        int guard;
        guard = 0;
        cmd_bus.valid <= 1'b0;
        while (pending_strobes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] strobe_raw,
                               input logic [CFG_DATA_W-1:0] ctrl_settle,
                               input logic [CFG_DATA_W-1:0] data_settle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STROBE_WAIT;
        cfg_data  <= strobe_raw;
        @(posedge clk);
        cfg_index <= REG_CTRL_SETTLE;
        cfg_data  <= ctrl_settle;
        @(posedge clk);
        cfg_index <= REG_DATA_SETTLE;
        cfg_data  <= data_settle;
        @(posedge clk);
        // unmapped index must leave every register alone
        cfg_index <= REG_UNMAPPED;
        cfg_data  <= CFG_DATA_W'($urandom_range(0, 65535));
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cfg.strobe_wait = strobe_raw[STROBE_W-1:0];
        shadow_cfg.ctrl_settle = ctrl_settle;
        shadow_cfg.data_settle = data_settle;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_wait();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_command(CMD_INIT, 8'h00, 6'd0, 2'd0);
        send_command(CMD_CTRL, 8'h00, 6'd0, 2'd0);
        send_command(CMD_CTRL, 8'hFF, 6'd63, 2'd3);
        send_command(CMD_DATA, 8'h00, 6'd0, 2'd0);
        send_command(CMD_DATA, 8'hFF, 6'd63, 2'd3);
        send_command(CMD_DATA, 8'h5A, 6'd21, 2'd1);
        send_command(CMD_CURSOR, 8'hFF, 6'd0, TOP_ROW);
        send_command(CMD_CURSOR, 8'h00, 6'd63, BOTTOM_ROW);
        send_command(CMD_CURSOR, 8'h00, 6'd63, TOP_ROW);
        send_command(CMD_CURSOR, 8'h33, 6'd21, 2'd2);
        send_command(CMD_CURSOR, 8'hCC, 6'd63, 2'd3);
        settle_all();
    endtask

    task automatic test_config_extremes();
        // largest waits: control settle sums saturate
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(CMD_INIT, 8'h00, 6'd0, 2'd0);
        send_command(CMD_CTRL, 8'hA5, 6'd0, 2'd0);
        send_command(CMD_DATA, 8'hC3, 6'd0, 2'd0);
        send_command(CMD_CURSOR, 8'h00, 6'd5, BOTTOM_ROW);
        settle_all();
        load_config(16'h0000, 16'h0000, 16'h0000);
        send_command(CMD_INIT, 8'h00, 6'd0, 2'd0);
        send_command(CMD_CTRL, 8'h3C, 6'd0, 2'd0);
        send_command(CMD_DATA, 8'h81, 6'd0, 2'd0);
        send_command(CMD_CURSOR, 8'h00, 6'd42, TOP_ROW);
        settle_all();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++)
        begin
            load_config(pick_wait(), pick_wait(), pick_wait());
            repeat (30) send_random_command();
            settle_all();
        end
    endtask

    task automatic test_sink_backpressure();
        load_config(CFG_DATA_W'($urandom_range(0, 65535)), pick_wait(), pick_wait());
        sink_hold_len = 400;
        repeat (12) send_random_command();
        settle_all();
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        load_config(pick_wait(), pick_wait(), pick_wait());
        repeat (20) send_random_command();
        settle_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_INIT;
        cmd_bus.value = '0;
        cmd_bus.column = '0;
        cmd_bus.row = '0;
        fault_count = 0;
        no_idle = 1'b0;
        sink_hold_len = 0;
        shadow_cfg.strobe_wait = DEFAULT_STROBE;
        shadow_cfg.ctrl_settle = DEFAULT_CTRL_SETTLE;
        shadow_cfg.data_settle = DEFAULT_DATA_SETTLE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_phases();
        test_sink_backpressure();
        test_full_rate();

        if (pending_strobes.size() != 0)
            $display("%0d expected strobes never arrived", pending_strobes.size());
        if (fault_count == 0 && pending_strobes.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
